@@ src/assert_macros.svh @@
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

@@ src/fsc_pkg.sv @@
// ---------------------------------------------------------------------------
// fsc_pkg
// types and constants shared by the fuzzy speed controller modules
// ---------------------------------------------------------------------------
package fsc_pkg;

    localparam int GRADE_W = 8;
    localparam int AREA_W = 17;
    localparam int NUM_W = 27;
    localparam int DEN_W = 19;
    localparam int QUO_W = 10;

    typedef logic [GRADE_W-1:0] grade_t;

    // rule strengths per output set
    typedef struct packed {
        grade_t brake;
        grade_t steady;
        grade_t gas;
    } strength_t;

    // weighted sums for the centroid division
    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } sums_t;

    // trapezoid grade, x pre-clamped by caller to a narrow range
    function automatic grade_t trap_grade(input logic signed [11:0] x,
                                          input int left, input int right,
                                          input int rise, input int fall);
        logic signed [12:0] d1;
        logic signed [12:0] d2;
        logic signed [20:0] p1;
        logic signed [20:0] p2;
        logic signed [20:0] m;
        d1 = 13'(x) - 13'(left);
        d2 = 13'(right) - 13'(x);
        p1 = 21'(d1) * 21'(rise);
        p2 = 21'(d2) * 21'(fall);
        m = (p1 < p2) ? p1 : p2;
        if (d1 <= 0 || d2 <= 0) begin
            return '0;
        end else if (m > 21'sd255) begin
            return 8'd255;
        end
        return m[7:0];
    endfunction

    // clipped trapezoid area h*(2*base - h/rise - h/fall)/2
    function automatic logic [AREA_W-1:0] clip_area(input grade_t h, input int base,
                                                    input int rise, input int fall);
        logic [10:0] top2;
        logic [19:0] prod;
        top2 = 11'(2 * base) - 11'(h / 8'(rise)) - 11'(h / 8'(fall));
        prod = 20'(h) * 20'(top2);
        return AREA_W'(prod >> 1);
    endfunction

    function automatic grade_t gmin(input grade_t a, input grade_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic grade_t gmax(input grade_t a, input grade_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ src/fsc_fuzz.sv @@
// ---------------------------------------------------------------------------
// fsc_fuzz
// fuzzification and rule evaluation, two register stages
// ---------------------------------------------------------------------------
module fsc_fuzz #(
    parameter int INPUT_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [INPUT_WIDTH-1:0] lat,
    input  logic signed [INPUT_WIDTH-1:0] lon,
    output logic                          out_valid,
    output fsc_pkg::strength_t            strength
);
    import fsc_pkg::*;

    logic               v1_reg;
    logic [4:0][7:0]    g_reg;
    logic [4:0][7:0]    g_next;
    logic               v2_reg;
    strength_t          s_reg;
    strength_t          s_next;
    logic signed [11:0] lat_c;
    logic signed [11:0] lon_c;

    // clamp inputs to a range that covers every trapezoid
    always_comb begin
        lat_c = (lat > INPUT_WIDTH'(400)) ? 12'sd400 :
                (lat < -INPUT_WIDTH'(400)) ? -12'sd400 : 12'(lat);
        lon_c = (lon > INPUT_WIDTH'(400)) ? 12'sd400 :
                (lon < -INPUT_WIDTH'(400)) ? -12'sd400 : 12'(lon);
        g_next[0] = trap_grade(lat_c, 0, 15, 127, 23);
        g_next[1] = trap_grade(lat_c, 4, 20, 23, 127);
        g_next[2] = trap_grade(lon_c, 0, 150, 127, 2);
        g_next[3] = trap_grade(lon_c, 60, 240, 3, 3);
        g_next[4] = trap_grade(lon_c, 150, 300, 2, 127);
    end

    // min/max rule base
    always_comb begin
        s_next.brake  = gmax(gmax(g_reg[2], gmin(g_reg[3], g_reg[1])),
                             gmin(g_reg[4], g_reg[1]));
        s_next.steady = gmin(g_reg[2], g_reg[1]);
        s_next.gas    = gmin(g_reg[4], g_reg[0]);
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            g_reg <= g_next;
            s_reg <= s_next;
        end
    end

    assign out_valid = v2_reg;
    assign strength  = s_reg;
endmodule

@@ src/fsc_defuzz.sv @@
// ---------------------------------------------------------------------------
// fsc_defuzz
// clipped areas and weighted sums, two register stages
// ---------------------------------------------------------------------------
module fsc_defuzz (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  fsc_pkg::strength_t strength,
    output logic               out_valid,
    output fsc_pkg::sums_t     sums
);
    import fsc_pkg::*;

    logic              v1_reg;
    logic [AREA_W-1:0] ab_reg, as_reg, ag_reg;
    logic              v2_reg;
    sums_t             sums_reg;
    sums_t             sums_next;

    // centroids: brake -200, steady 0, gas 200
    always_comb begin
        sums_next.num = NUM_W'(signed'({1'b0, ag_reg}) - signed'({1'b0, ab_reg}))
                        * NUM_W'(200);
        sums_next.den = DEN_W'(ab_reg) + DEN_W'(as_reg) + DEN_W'(ag_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            ab_reg   <= clip_area(strength.brake, 400, 3, 1);
            as_reg   <= clip_area(strength.steady, 510, 1, 1);
            ag_reg   <= clip_area(strength.gas, 400, 1, 3);
            sums_reg <= sums_next;
        end
    end

    assign out_valid = v2_reg;
    assign sums      = sums_reg;
endmodule

@@ src/fsc_div.sv @@
// ---------------------------------------------------------------------------
// fsc_div
// pipelined restoring divider, one quotient bit per stage, then banding
// ---------------------------------------------------------------------------
module fsc_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  fsc_pkg::sums_t        sums,
    output logic                  out_valid,
    output logic signed [3:0]     esc_step,
    output logic signed [9:0]     drive_value,
    output logic                  any_rule_fired
);
    import fsc_pkg::*;

    localparam int NS = QUO_W;
    localparam int MAG_W = NUM_W - 1;

    logic [NS:0]            v_reg;
    logic [NS:0][MAG_W-1:0] rem_reg;
    logic [NS:0][DEN_W-1:0] den_reg;
    logic [NS:0][QUO_W-1:0] q_reg;
    logic [NS:0]            neg_reg;
    logic [MAG_W-1:0]       mag_in;
    logic signed [9:0]      drv;
    logic                   fired;
    logic signed [3:0]      step_reg, step_next;
    logic signed [9:0]      drive_reg;
    logic                   fired_reg;
    logic                   vo_reg;

    assign mag_in = sums.num[NUM_W-1] ? MAG_W'(-sums.num) : MAG_W'(sums.num);

    // each stage produces one quotient bit, msb first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v_reg  <= {v_reg[NS-1:0], in_valid};
            vo_reg <= v_reg[NS];
        end
        if (en) begin
            rem_reg[0] <= mag_in;
            den_reg[0] <= sums.den;
            q_reg[0]   <= '0;
            neg_reg[0] <= sums.num[NUM_W-1];
            for (int i = 0; i < NS; i++) begin
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                if (rem_reg[i] >= (MAG_W+QUO_W)'(den_reg[i]) << (NS-1-i)) begin
                    rem_reg[i+1] <= rem_reg[i]
                                    - MAG_W'((MAG_W+QUO_W)'(den_reg[i]) << (NS-1-i));
                    q_reg[i+1]   <= q_reg[i] | QUO_W'(1 << (NS-1-i));
                end else begin
                    rem_reg[i+1] <= rem_reg[i];
                    q_reg[i+1]   <= q_reg[i];
                end
            end
            step_reg  <= step_next;
            drive_reg <= drv;
            fired_reg <= fired;
        end
    end

    // sign, zero area, banding (lower step wins at ties)
    always_comb begin
        fired = den_reg[NS] != '0;
        drv = !fired ? 10'sd0 :
              neg_reg[NS] ? -signed'(q_reg[NS]) : signed'(q_reg[NS]);
        step_next = '0;
        for (int k = 4; k >= -4; k--) begin
            if (12'(drv) <= 12'(k*100+50) && 12'(drv) >= 12'(k*100-50)) begin
                step_next = 4'(k);
            end
        end
    end

    assign out_valid      = vo_reg;
    assign esc_step       = step_reg;
    assign drive_value    = drive_reg;
    assign any_rule_fired = fired_reg;
endmodule

@@ src/fuzzy_speed_controller_unit.sv @@
// throughput: one request per cycle while no stall holds the pipeline
// a stall freezes the whole pipeline, so no skid buffer is needed
// reset: synchronous, active low, clears every valid bit
// ---------------------------------------------------------------------------
// fuzzy_speed_controller_unit
// pipelined mamdani fuzzy controller for a speed step
// ---------------------------------------------------------------------------
module fuzzy_speed_controller_unit #(
    parameter int INPUT_WIDTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // lateral_offset, longitudinal_distance
    input  logic [2*INPUT_WIDTH-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // esc_step[3:0], drive_value[13:4], any_rule_fired[14], zero pad
    output logic [15:0]                m_tdata
);
    import fsc_pkg::*;

    logic        en;
    logic        v_fz, v_df;
    strength_t   strength;
    sums_t       sums;
    logic signed [3:0] step;
    logic signed [9:0] drv;
    logic        fired;

    // pipeline advances unless a held result is not taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    fsc_fuzz #(.INPUT_WIDTH(INPUT_WIDTH)) u_fuzz (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid),
        .lat(s_tdata[INPUT_WIDTH-1:0]), .lon(s_tdata[2*INPUT_WIDTH-1:INPUT_WIDTH]),
        .out_valid(v_fz), .strength(strength)
    );

    fsc_defuzz u_defuzz (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_fz),
        .strength(strength), .out_valid(v_df), .sums(sums)
    );

    fsc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_df), .sums(sums),
        .out_valid(m_tvalid), .esc_step(step), .drive_value(drv),
        .any_rule_fired(fired)
    );

    assign m_tdata = {1'b0, fired, drv, step};
endmodule

@@ src/fsc_checker.sv @@
// ---------------------------------------------------------------------------
// fsc_checker
// port-level checks on the result stream and on s_tready
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPL(a_nofire, aclk, aresetn, m_tvalid && !m_tdata[14], m_tdata[13:0] == 14'd0)
    `ASSERT_IMPL(a_ready, aclk, aresetn, !m_tvalid, s_tready)
    `ASSERT_IMPL(a_step, aclk, aresetn, m_tvalid,
                 $signed(m_tdata[3:0]) <= 4'sd4 && $signed(m_tdata[3:0]) >= -4'sd4)
endmodule

bind fuzzy_speed_controller_unit fsc_checker u_fsc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
